@@ design/frt_pkg.sv @@
// ----------------------------------------------------------------------------
// frt_pkg: shared types and constants for the filmic rational tonemapper
// Holds the fixed-point widths, the scaled curve coefficients, the divider
// state type and the single restoring division step used by every lane.
// ----------------------------------------------------------------------------
package frt_pkg;

    localparam int IN_W     = 24;
    localparam int OUT_W    = 16;
    localparam int FRAC_W   = 16;
    localparam int COEF_W   = 9;
    localparam int LIN_W    = IN_W + COEF_W;
    localparam int PROD_W   = 2 * IN_W + COEF_W;
    localparam int N_LANES  = 3;
    // Front stage, product stage, OUT_W-1 division stages, output register.
    localparam int N_STAGES = OUT_W + 2;

    localparam int IN_BUS_W  = 8 * ((N_LANES * IN_W + 7) / 8);
    localparam int OUT_BUS_W = 8 * ((N_LANES * OUT_W + 7) / 8);

    // Curve scaled by 50: x*(310x + 25) / (x*(310x + 85) + 3), in Q8.16 codes.
    localparam logic [COEF_W-1:0] K_SQ  = COEF_W'(310);
    localparam logic [LIN_W-1:0]  K_NUM = LIN_W'(25 << FRAC_W);
    localparam logic [LIN_W-1:0]  K_DEN = LIN_W'(85 << FRAC_W);
    localparam logic [PROD_W-1:0] K_OFS = PROD_W'(64'd3 << (2 * FRAC_W));

    typedef logic [IN_W-1:0]   chan_t;
    typedef logic [PROD_W-1:0] prod_t;
    typedef logic [OUT_W-1:0]  quo_t;

    typedef struct packed {
        prod_t rem;
        prod_t den;
        quo_t  q;
    } div_t;

    // One restoring step: shift the remainder, try the subtract, shift in the bit.
    function automatic div_t div_step(div_t s);
        logic [PROD_W:0]   r2;
        logic [PROD_W+1:0] diff;
        logic              ge;
        div_t              r;
        r2   = {s.rem, 1'b0};
        diff = {1'b0, r2} - {2'b00, s.den};
        ge   = ~diff[PROD_W+1];
        r.den = s.den;
        r.rem = ge ? diff[PROD_W-1:0] : r2[PROD_W-1:0];
        r.q   = {s.q[OUT_W-2:0], ge};
        return r;
    endfunction

endpackage

@@ design/filmic_rational_tonemap.sv @@
// ----------------------------------------------------------------------------
// filmic_rational_tonemap: per-pixel filmic rational tone curve
//
//   Channel   Dir  Signals                     Content
//   s_        in   s_tvalid s_tready s_tdata   red_in, green_in, blue_in
//   m_        out  m_tvalid m_tready m_tdata   red_out, green_out, blue_out
//
// One pixel is accepted per clock while s_tready is high. Each item passes
// two polynomial stages, fifteen divider stages and the output register,
// the first of them loaded at the accepting edge. Every stage has its own
// valid bit and moves as soon as the stage after it is free, so bubbles
// close up under a stall.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module filmic_rational_tonemap
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // red_in [23:0], green_in [47:24], blue_in [71:48]
    input  logic [frt_pkg::IN_BUS_W-1:0]     s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // red_out [15:0], green_out [31:16], blue_out [47:32]
    output logic [frt_pkg::OUT_BUS_W-1:0]    m_tdata
);

    logic [frt_pkg::N_STAGES-1:0] valid_reg;
    logic [frt_pkg::N_STAGES-1:0] valid_next;
    logic [frt_pkg::N_STAGES-1:0] ready;
    logic [frt_pkg::N_STAGES-1:0] upstream;
    logic [frt_pkg::N_STAGES-1:0] load;
    frt_pkg::quo_t                q [frt_pkg::N_LANES];

    // A stage can take a new item when it is empty or its item moves on.
    always_comb
    begin
        ready[frt_pkg::N_STAGES-1] = ~valid_reg[frt_pkg::N_STAGES-1] | m_tready;
        for (int k = frt_pkg::N_STAGES - 2; k >= 0; k--)
        begin
            ready[k] = ~valid_reg[k] | ready[k+1];
        end
    end

    assign upstream   = {valid_reg[frt_pkg::N_STAGES-2:0], s_tvalid};
    assign load       = ready & upstream;
    assign valid_next = (ready & upstream) | (~ready & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    for (genvar i = 0; i < frt_pkg::N_LANES; i++)
    begin : g_lane
        frt_lane u_lane
        (
            .clk  (clk),
            .load (load[frt_pkg::N_STAGES-2:0]),
            .x    (s_tdata[i*frt_pkg::IN_W +: frt_pkg::IN_W]),
            .q    (q[i])
        );
    end

    frt_merge u_merge
    (
        .clk   (clk),
        .load  (load[frt_pkg::N_STAGES-1]),
        .q     (q),
        .tdata (m_tdata)
    );

    assign s_tready = ready[0];
    assign m_tvalid = valid_reg[frt_pkg::N_STAGES-1];

`ifndef SYNTH
    // The input side only stalls when every stage is full and the output waits.
    a_stall_needs_full_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while the output register could move");

    // With nothing in flight and the output taken, the output goes empty.
    a_drain_empties_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        (valid_reg[frt_pkg::N_STAGES-2:0] == '0 && m_tready) |=> !m_tvalid)
        else $error("output valid without an item in the pipeline");

    // An item taken at the output is replaced only by one from the stage before.
    a_output_refill: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready) |=> (m_tvalid == $past(valid_reg[frt_pkg::N_STAGES-2])))
        else $error("output refill does not match the last divider stage");
`endif

endmodule

@@ design/frt_front.sv @@
// ----------------------------------------------------------------------------
// frt_front: numerator and denominator polynomials of one channel
// Stage one forms the two linear terms, stage two multiplies them by x and
// adds the constant to the denominator, giving the divider's start state.
// ----------------------------------------------------------------------------
module frt_front
(
    input  logic             clk,
    input  logic             load_a,
    input  logic             load_b,
    input  frt_pkg::chan_t   x,
    output frt_pkg::div_t    start
);

    frt_pkg::chan_t                  x_reg;
    logic [frt_pkg::LIN_W-1:0]       sq;
    logic [frt_pkg::LIN_W-1:0]       lin_num_next;
    logic [frt_pkg::LIN_W-1:0]       lin_den_next;
    logic [frt_pkg::LIN_W-1:0]       lin_num_reg;
    logic [frt_pkg::LIN_W-1:0]       lin_den_reg;
    frt_pkg::prod_t                  num_next;
    frt_pkg::prod_t                  den_next;
    frt_pkg::prod_t                  num_reg;
    frt_pkg::prod_t                  den_reg;

    assign sq           = frt_pkg::LIN_W'(x) * frt_pkg::LIN_W'(frt_pkg::K_SQ);
    assign lin_num_next = sq + frt_pkg::K_NUM;
    assign lin_den_next = sq + frt_pkg::K_DEN;

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            x_reg       <= x;
            lin_num_reg <= lin_num_next;
            lin_den_reg <= lin_den_next;
        end
    end

    assign num_next = frt_pkg::PROD_W'(x_reg) * frt_pkg::PROD_W'(lin_num_reg);
    assign den_next = frt_pkg::PROD_W'(x_reg) * frt_pkg::PROD_W'(lin_den_reg)
                      + frt_pkg::K_OFS;

    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    assign start.rem = num_reg;
    assign start.den = den_reg;
    assign start.q   = '0;

endmodule

@@ design/frt_div_step.sv @@
// ----------------------------------------------------------------------------
// frt_div_step: one registered stage of the restoring divider
// Produces one quotient bit per stage and passes remainder and divisor on.
// ----------------------------------------------------------------------------
module frt_div_step
(
    input  logic           clk,
    input  logic           load,
    input  frt_pkg::div_t  din,
    output frt_pkg::div_t  dout
);

    frt_pkg::div_t step_next;
    frt_pkg::div_t step_reg;

    assign step_next = frt_pkg::div_step(din);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            step_reg <= step_next;
        end
    end

    assign dout = step_reg;

endmodule

@@ design/frt_lane.sv @@
// ----------------------------------------------------------------------------
// frt_lane: one channel of the tonemapper
// Polynomial front end followed by a pipelined restoring divider; the last
// quotient bit is resolved combinationally into the output register.
// ----------------------------------------------------------------------------
module frt_lane
(
    input  logic                            clk,
    input  logic [frt_pkg::N_STAGES-2:0]    load,
    input  frt_pkg::chan_t                  x,
    output frt_pkg::quo_t                   q
);

    frt_pkg::div_t st [frt_pkg::OUT_W];
    frt_pkg::div_t last_step;

    frt_front u_front
    (
        .clk    (clk),
        .load_a (load[0]),
        .load_b (load[1]),
        .x      (x),
        .start  (st[0])
    );

    for (genvar i = 1; i < frt_pkg::OUT_W; i++)
    begin : g_step
        frt_div_step u_step
        (
            .clk  (clk),
            .load (load[i+1]),
            .din  (st[i-1]),
            .dout (st[i])
        );
    end

    // The numerator is always below the denominator, so the quotient fits
    // in OUT_W bits and never passes the top code.
    assign last_step = frt_pkg::div_step(st[frt_pkg::OUT_W-1]);
    assign q         = last_step.q;

endmodule

@@ design/frt_merge.sv @@
// ----------------------------------------------------------------------------
// frt_merge: output register that joins the three lanes
// Packs the per-channel quotients into one output word, red in the low bits.
// ----------------------------------------------------------------------------
module frt_merge
(
    input  logic                             clk,
    input  logic                             load,
    input  frt_pkg::quo_t                    q [frt_pkg::N_LANES],
    output logic [frt_pkg::OUT_BUS_W-1:0]    tdata
);

    logic [frt_pkg::OUT_BUS_W-1:0] tdata_next;
    logic [frt_pkg::OUT_BUS_W-1:0] tdata_reg;

    always_comb
    begin
        tdata_next = '0;
        for (int i = 0; i < frt_pkg::N_LANES; i++)
        begin
            tdata_next[i*frt_pkg::OUT_W +: frt_pkg::OUT_W] = q[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tdata_reg <= tdata_next;
        end
    end

    assign tdata = tdata_reg;

endmodule

@@ test/tb_filmic_rational_tonemap.sv @@
// ----------------------------------------------------------------------------
// tb_filmic_rational_tonemap: self-checking bench for the filmic tone curve
// Streams HDR pixels into the block, predicts each tonemapped pixel with an
// exact wide-integer division of the rational curve, and compares every
// output item channel by channel. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_filmic_rational_tonemap;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        frt_pkg::chan_t red;
        frt_pkg::chan_t green;
        frt_pkg::chan_t blue;
        int unsigned    gap;
        bit             drain;
    } hdr_pixel_t;

    typedef struct {
        frt_pkg::quo_t red;
        frt_pkg::quo_t green;
        frt_pkg::quo_t blue;
    } ldr_pixel_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [frt_pkg::IN_BUS_W-1:0]  s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [frt_pkg::OUT_BUS_W-1:0] m_tdata;

    hdr_pixel_t  hdr_q[$];
    ldr_pixel_t  ldr_q[$];
    logic        in_fire = 1'b0;
    int unsigned n_pixels_in = 0;
    int unsigned n_pixels_out = 0;
    int unsigned n_mismatch = 0;
    int unsigned n_directed = 0;
    int unsigned rx_mode = 0;
    int unsigned stall_reqs = 0;
    int unsigned stall_done = 0;
    int unsigned stall_left = 0;

    filmic_rational_tonemap uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Exact curve: floor(2^16 * X(310X + 25*2^16) / (X(310X + 85*2^16) + 3*2^32)).
    function automatic frt_pkg::quo_t filmic_curve(frt_pkg::chan_t x);
        logic [127:0] xw;
        logic [127:0] numer;
        logic [127:0] denom;
        logic [127:0] quot;
        xw    = 128'(x);
        numer = xw * (xw * 128'd310 + (128'd25 << frt_pkg::FRAC_W));
        denom = xw * (xw * 128'd310 + (128'd85 << frt_pkg::FRAC_W))
                + (128'd3 << (2 * frt_pkg::FRAC_W));
        quot  = (numer << frt_pkg::OUT_W) / denom;
        if (quot > 128'((1 << frt_pkg::OUT_W) - 1))
            return '1;
        return quot[frt_pkg::OUT_W-1:0];
    endfunction

    function automatic frt_pkg::chan_t pick_channel();
        int unsigned sel;
        sel = $urandom_range(9);
        case (sel) inside
            [0:3]:   return frt_pkg::chan_t'($urandom);
            [4:6]:   return frt_pkg::chan_t'($urandom_range(32'h3FFFF));
            7:       return frt_pkg::chan_t'($urandom_range(255));
            8:       return frt_pkg::chan_t'(24'hFFFFFF - $urandom_range(4095));
            default: return frt_pkg::chan_t'(1) << $urandom_range(frt_pkg::IN_W - 1);
        endcase
    endfunction

    function automatic int unsigned pick_gap(int unsigned mode);
        int unsigned r;
        r = $urandom_range(99);
        if (mode == 0)
            return 0;
        if (mode == 1)
        begin
            if (r < 70)
                return 0;
            if (r < 95)
                return $urandom_range(3, 1);
            return $urandom_range(20, 4);
        end
        if (r < 40)
            return 0;
        if (r < 80)
            return $urandom_range(4, 1);
        if (r < 95)
            return $urandom_range(15, 5);
        return $urandom_range(60, 20);
    endfunction

    task automatic queue_pixel(frt_pkg::chan_t r, frt_pkg::chan_t g, frt_pkg::chan_t b,
                               int unsigned gap, bit drain);
        hdr_pixel_t p;
        p.red   = r;
        p.green = g;
        p.blue  = b;
        p.gap   = gap;
        p.drain = drain;
        hdr_q.push_back(p);
    endtask

    // Input side: a pixel at the head of the queue waits out its gap first.
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_fire))
        begin
            if (hdr_q.size() == 0 || (hdr_q[0].drain && ldr_q.size() != 0))
                s_tvalid <= 1'b0;
            else if (hdr_q[0].gap > 0)
            begin
                hdr_q[0].gap = hdr_q[0].gap - 1;
                s_tvalid <= 1'b0;
            end
            else
            begin
                s_tdata  <= frt_pkg::IN_BUS_W'({hdr_q[0].blue, hdr_q[0].green,
                                                hdr_q[0].red});
                s_tvalid <= 1'b1;
                void'(hdr_q.pop_front());
            end
        end
    end

    // Output side: random ready, plus long holds requested by the stimulus.
    always @(negedge clk)
    begin
        logic rdy;
        if (stall_reqs != stall_done)
        begin
            stall_left = 300;
            stall_done = stall_done + 1;
        end
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            rdy = 1'b0;
        end
        else
        begin
            case (rx_mode)
                0:       rdy = 1'b1;
                1:       rdy = ($urandom_range(99) < 75);
                default:
                begin
                    rdy = ($urandom_range(99) < 90);
                    if ($urandom_range(99) < 3)
                        stall_left = $urandom_range(40, 10);
                end
            endcase
        end
        m_tready <= rdy;
    end

    // Prediction on input acceptance, checking on output acceptance.
    always @(posedge clk)
    begin
        ldr_pixel_t     want;
        ldr_pixel_t     got;
        frt_pkg::chan_t r, g, b;
        in_fire <= s_tvalid && s_tready;
        if (rst_n && s_tvalid && s_tready)
        begin
            r = s_tdata[frt_pkg::IN_W-1:0];
            g = s_tdata[2*frt_pkg::IN_W-1:frt_pkg::IN_W];
            b = s_tdata[3*frt_pkg::IN_W-1:2*frt_pkg::IN_W];
            want.red   = filmic_curve(r);
            want.green = filmic_curve(g);
            want.blue  = filmic_curve(b);
            ldr_q.push_back(want);
            n_pixels_in = n_pixels_in + 1;
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got.red   = m_tdata[frt_pkg::OUT_W-1:0];
            got.green = m_tdata[2*frt_pkg::OUT_W-1:frt_pkg::OUT_W];
            got.blue  = m_tdata[3*frt_pkg::OUT_W-1:2*frt_pkg::OUT_W];
            n_pixels_out = n_pixels_out + 1;
            if (ldr_q.size() == 0)
            begin
                $display("%t: unexpected output item, actual r=%h g=%h b=%h",
                         $realtime, got.red, got.green, got.blue);
                n_mismatch = n_mismatch + 1;
            end
            else
            begin
                want = ldr_q.pop_front();
                if (got.red !== want.red)
                begin
                    $display("%t: red mismatch, expected %h actual %h",
                             $realtime, want.red, got.red);
                    n_mismatch = n_mismatch + 1;
                end
                if (got.green !== want.green)
                begin
                    $display("%t: green mismatch, expected %h actual %h",
                             $realtime, want.green, got.green);
                    n_mismatch = n_mismatch + 1;
                end
                if (got.blue !== want.blue)
                begin
                    $display("%t: blue mismatch, expected %h actual %h",
                             $realtime, want.blue, got.blue);
                    n_mismatch = n_mismatch + 1;
                end
            end
        end
    end

    initial
    begin
        frt_pkg::chan_t corner[12];
        int unsigned    gap_mode;
        corner = '{24'h000000, 24'h000001, 24'hFFFFFF, 24'h010000, 24'h800000,
                   24'h7FFFFF, 24'h000100, 24'hAAAAAA, 24'h555555, 24'h00FFFF,
                   24'h000002, 24'h100000};
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // Corner codes: zero, one LSB, full scale, 1.0, alternating bits.
        queue_pixel(24'h000000, 24'h000000, 24'h000000, 0, 1'b0);
        queue_pixel(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 1'b0);
        for (int i = 0; i < 12; i++)
            queue_pixel(corner[i], corner[(i + 3) % 12], corner[(i + 7) % 12],
                        i % 3, 1'b0);
        n_directed = hdr_q.size();

        // Hold the output for a long stretch while pixels keep coming.
        stall_reqs = stall_reqs + 1;
        for (int i = 0; i < 80; i++)
            queue_pixel(pick_channel(), pick_channel(), pick_channel(), 0, 1'b0);
        // This one waits until the pipeline has fully drained.
        queue_pixel(pick_channel(), pick_channel(), pick_channel(), 0, 1'b1);

        for (int seg = 0; seg < 7; seg++)
        begin
            while (hdr_q.size() > 0)
                @(negedge clk);
            gap_mode = (seg == 0) ? 0 : $urandom_range(2);
            rx_mode  = (seg == 0) ? 0 : $urandom_range(2);
            for (int i = 0; i < 100; i++)
                queue_pixel(pick_channel(), pick_channel(), pick_channel(),
                            pick_gap(gap_mode), (i == 0 && seg == 4));
        end

        while (hdr_q.size() > 0 || s_tvalid || ldr_q.size() > 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("Tonemapped %0d pixels (%0d directed corners) and checked %0d results,",
                 n_pixels_in, n_directed, n_pixels_out);
        $display("with idle gaps and stalls on both sides and one long output hold.");
        if (n_mismatch == 0)
            $display("tb_filmic_rational_tonemap: PASS");
        else
            $display("tb_filmic_rational_tonemap: FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timeout with %0d pixels in flight.", ldr_q.size());
        $display("tb_filmic_rational_tonemap: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
design/frt_pkg.sv
design/frt_front.sv
design/frt_div_step.sv
design/frt_lane.sv
design/frt_merge.sv
design/filmic_rational_tonemap.sv
test/tb_filmic_rational_tonemap.sv
